// ===== src/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants for the vector program sequencer: opcodes,
// sequencing phases, configuration register indexes and state structures.
// ----------------------------------------------------------------------------
package sps_pkg;

    // Fixed field widths.
    localparam int WORD_ADDR_BITS = 8;
    localparam int OP_BITS        = 4;
    localparam int CFG_WIDTH      = 9;
    localparam int CFG_IDX_BITS   = 3;
    localparam int SIZE_BITS      = 9;
    localparam int LANE_BITS      = 4;

    // Program word opcodes.
    localparam logic [OP_BITS-1:0] OP_NOP    = 4'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD_A = 4'd1;
    localparam logic [OP_BITS-1:0] OP_LOAD_B = 4'd2;
    localparam logic [OP_BITS-1:0] OP_ADD    = 4'd3;
    localparam logic [OP_BITS-1:0] OP_DOT    = 4'd6;
    localparam logic [OP_BITS-1:0] OP_BUF1   = 4'd7;
    localparam logic [OP_BITS-1:0] OP_BUF2   = 4'd8;
    localparam logic [OP_BITS-1:0] OP_STORE  = 4'd9;
    localparam logic [OP_BITS-1:0] OP_STOP   = 4'd10;

    // Sequencing phases.
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_TOP  = 3'd1;
    localparam logic [2:0] PH_LB   = 3'd2;
    localparam logic [2:0] PH_MID  = 3'd3;
    localparam logic [2:0] PH_BUF  = 3'd4;
    localparam logic [2:0] PH_ST   = 3'd5;
    localparam logic [2:0] PH_FIN  = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ELEM_OPCODE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROWS        = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INNER       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLS        = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LANES_LOG2  = 3'd5;

    // Configuration register file contents.
    typedef struct packed {
        logic                    mode;
        logic [OP_BITS-1:0]      elem_opcode;
        logic [SIZE_BITS-1:0]    rows;
        logic [SIZE_BITS-1:0]    inner;
        logic [SIZE_BITS-1:0]    cols;
        logic [2:0]              lanes_log2;
    } t_cfg;

    // Loop position of the program.
    typedef struct packed {
        logic [7:0]           row_index;
        logic [7:0]           col_group_index;
        logic [LANE_BITS-1:0] lane_index;
        logic [7:0]           inner_index;
        logic [2:0]           phase;
        logic                 running;
    } t_state;

endpackage

// ===== src/sps_step.sv =====
// ----------------------------------------------------------------------------
// sps_step
// Next-word logic: from the current loop position, the configuration and
// the restart bit, forms the next program word and the next loop position.
// ----------------------------------------------------------------------------
module sps_step #(
    parameter int ADDR_BITS = sps_pkg::WORD_ADDR_BITS
) (
    input  sps_pkg::t_cfg                       i_cfg,
    input  sps_pkg::t_state                     i_state,
    input  logic                                i_restart,
    output sps_pkg::t_state                     o_state,
    output logic                                o_emit,
    output logic [sps_pkg::OP_BITS-1:0]         o_opcode,
    output logic [ADDR_BITS-1:0]                o_address,
    output logic                                o_last
);

    localparam int PROD_W = 2 * sps_pkg::SIZE_BITS;
    localparam int SUM_W  = PROD_W + 1;

    logic [2:0]                    lanes_l;
    logic [4:0]                    lanes_w;
    logic [sps_pkg::SIZE_BITS-1:0] size_m;
    logic [sps_pkg::SIZE_BITS-1:0] size_n;
    logic [sps_pkg::SIZE_BITS-1:0] size_p;
    logic [sps_pkg::SIZE_BITS-1:0] groups_n;
    logic [sps_pkg::SIZE_BITS-1:0] mul_a;
    logic [sps_pkg::SIZE_BITS-1:0] mul_b;
    logic [sps_pkg::SIZE_BITS-1:0] addend;
    logic [PROD_W-1:0]             prod;
    logic [PROD_W-1:0]             prod_sh;
    logic [SUM_W-1:0]              addr_sum;
    logic [ADDR_BITS-1:0]          addr;
    logic                          at_top;
    logic [2:0]                    eff_phase;
    logic [sps_pkg::SIZE_BITS-1:0] n_plus;
    logic [sps_pkg::SIZE_BITS-1:0] p_plus;
    logic [sps_pkg::SIZE_BITS-1:0] m_plus;
    logic [4:0]                    w_plus;
    logic [sps_pkg::SIZE_BITS-1:0] pw_sum;

    // Clamp sizes and lane count to their legal ranges.
    always_comb begin
        lanes_l  = (i_cfg.lanes_log2 > 3'd4) ? 3'd4 : i_cfg.lanes_log2;
        lanes_w  = 5'd1 << lanes_l;
        size_m   = (i_cfg.rows  > 9'd256) ? 9'd256 : i_cfg.rows;
        size_n   = (i_cfg.inner > 9'd256) ? 9'd256 : i_cfg.inner;
        size_p   = (i_cfg.cols  > 9'd256) ? 9'd256 : i_cfg.cols;
        groups_n = size_n >> lanes_l;
    end

    // Shared address path: one multiply, a shift by the lane count, one add.
    always_comb begin
        pw_sum = {1'b0, i_state.col_group_index} + {5'b0, i_state.lane_index};
        mul_a  = {1'b0, i_state.row_index};
        mul_b  = size_n;
        addend = {1'b0, i_state.inner_index};
        if (i_cfg.mode) begin
            addend = {1'b0, i_state.inner_index} >> lanes_l;
        end else if (i_state.phase == sps_pkg::PH_LB) begin
            mul_a = pw_sum;
        end else if (i_state.phase == sps_pkg::PH_ST) begin
            mul_b  = size_p;
            addend = {1'b0, i_state.col_group_index} >> lanes_l;
        end
        prod     = mul_a * mul_b;
        prod_sh  = prod >> lanes_l;
        addr_sum = {1'b0, prod_sh} + {{(SUM_W-sps_pkg::SIZE_BITS){1'b0}}, addend};
        addr     = addr_sum[ADDR_BITS-1:0];
    end

    // Loop increments, one bit wider than the positions they compare against.
    always_comb begin
        n_plus = {1'b0, i_state.inner_index} + 9'd1;
        m_plus = {1'b0, i_state.row_index} + 9'd1;
        w_plus = {1'b0, i_state.lane_index} + 5'd1;
        p_plus = {1'b0, i_state.col_group_index} + {4'b0, lanes_w};
        at_top = (i_state.phase < sps_pkg::PH_LB) || (i_state.phase > sps_pkg::PH_ST);
    end

    // Program sequencing.
    always_comb begin
        o_state   = i_state;
        o_emit    = 1'b0;
        o_opcode  = sps_pkg::OP_NOP;
        o_address = '0;
        o_last    = 1'b0;
        eff_phase = i_state.phase;

        if (i_restart) begin
            o_state.row_index       = '0;
            o_state.col_group_index = '0;
            o_state.lane_index      = '0;
            o_state.inner_index     = '0;
            o_state.phase           = sps_pkg::PH_TOP;
            o_state.running         = 1'b1;
            o_emit                  = 1'b1;
        end else if (i_state.running) begin
            o_emit = 1'b1;
            if (i_state.phase == sps_pkg::PH_FIN) begin
                o_opcode        = sps_pkg::OP_STOP;
                o_last          = 1'b1;
                o_state.running = 1'b0;
                o_state.phase   = sps_pkg::PH_IDLE;
            end else if (!i_cfg.mode) begin
                // Matrix multiply program.
                if (at_top && ({1'b0, i_state.row_index} >= size_m || size_p == 9'd0)) begin
                    o_opcode        = sps_pkg::OP_STOP;
                    o_last          = 1'b1;
                    o_state.running = 1'b0;
                    o_state.phase   = sps_pkg::PH_IDLE;
                end else if (at_top && {1'b0, i_state.inner_index} < groups_n) begin
                    o_opcode      = sps_pkg::OP_LOAD_A;
                    o_address     = addr;
                    o_state.phase = sps_pkg::PH_LB;
                end else begin
                    // An exhausted inner loop at the top falls straight to BUF2.
                    if (at_top) begin
                        o_state.inner_index = '0;
                        eff_phase           = sps_pkg::PH_BUF;
                    end
                    unique case (eff_phase)
                        sps_pkg::PH_LB: begin
                            o_opcode      = sps_pkg::OP_LOAD_B;
                            o_address     = addr;
                            o_state.phase = sps_pkg::PH_MID;
                        end
                        sps_pkg::PH_MID: begin
                            o_opcode = sps_pkg::OP_DOT;
                            if (n_plus >= groups_n) begin
                                o_state.inner_index = '0;
                                o_state.phase       = sps_pkg::PH_BUF;
                            end else begin
                                o_state.inner_index = n_plus[7:0];
                                o_state.phase       = sps_pkg::PH_TOP;
                            end
                        end
                        sps_pkg::PH_BUF: begin
                            o_opcode = sps_pkg::OP_BUF2;
                            if (w_plus >= lanes_w) begin
                                o_state.lane_index = '0;
                                o_state.phase      = sps_pkg::PH_ST;
                            end else begin
                                o_state.lane_index = w_plus[sps_pkg::LANE_BITS-1:0];
                                o_state.phase      = sps_pkg::PH_TOP;
                            end
                        end
                        default: begin
                            o_opcode           = sps_pkg::OP_STORE;
                            o_address          = addr;
                            o_state.lane_index = '0;
                            if (p_plus >= size_p) begin
                                o_state.col_group_index = '0;
                                if (m_plus >= size_m) begin
                                    o_state.phase = sps_pkg::PH_FIN;
                                end else begin
                                    o_state.row_index = m_plus[7:0];
                                    o_state.phase     = sps_pkg::PH_TOP;
                                end
                            end else begin
                                o_state.col_group_index = p_plus[7:0];
                                o_state.phase           = sps_pkg::PH_TOP;
                            end
                        end
                    endcase
                end
            end else begin
                // Elementwise program.
                unique case (i_state.phase)
                    sps_pkg::PH_LB: begin
                        o_opcode      = sps_pkg::OP_LOAD_B;
                        o_address     = addr;
                        o_state.phase = sps_pkg::PH_MID;
                    end
                    sps_pkg::PH_MID: begin
                        o_opcode      = i_cfg.elem_opcode;
                        o_state.phase = sps_pkg::PH_BUF;
                    end
                    sps_pkg::PH_BUF: begin
                        o_opcode      = sps_pkg::OP_BUF1;
                        o_state.phase = sps_pkg::PH_ST;
                    end
                    sps_pkg::PH_ST: begin
                        o_opcode  = sps_pkg::OP_STORE;
                        o_address = addr;
                        if (({1'b0, i_state.inner_index} + {4'b0, lanes_w}) >= size_n) begin
                            o_state.inner_index = '0;
                            if (m_plus >= size_m) begin
                                o_state.phase = sps_pkg::PH_FIN;
                            end else begin
                                o_state.row_index = m_plus[7:0];
                                o_state.phase     = sps_pkg::PH_TOP;
                            end
                        end else begin
                            o_state.inner_index = i_state.inner_index + {3'b0, lanes_w};
                            o_state.phase       = sps_pkg::PH_TOP;
                        end
                    end
                    default: begin
                        if ({1'b0, i_state.row_index} >= size_m || size_n == 9'd0) begin
                            o_opcode        = sps_pkg::OP_STOP;
                            o_last          = 1'b1;
                            o_state.running = 1'b0;
                            o_state.phase   = sps_pkg::PH_IDLE;
                        end else begin
                            o_opcode      = sps_pkg::OP_LOAD_A;
                            o_address     = addr;
                            o_state.phase = sps_pkg::PH_LB;
                        end
                    end
                endcase
            end
        end
    end

endmodule

// ===== src/simd_program_sequencer.sv =====
// ----------------------------------------------------------------------------
// simd_program_sequencer
// Emits the instruction program for a vector unit, one word per input item
// taken while running or on restart, in matrix multiply or elementwise form.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                    Payload
//  input     in         i_in_valid / o_in_ready      i_restart
//  output    out        o_out_valid / i_out_ready    o_opcode, o_address, o_last
//  config    in         i_cfg_we                     i_cfg_index, i_cfg_data
//
//  Each taken item's word appears in the output register the cycle after.
//  One item per cycle is sustained while the output drains: the only path
//  is the next-word logic with its single shared address multiplier.
//  Reset is synchronous, clears the loop position and restores the default
//  configuration. A new item is taken while the output word is being
//  transferred; a stalled output holds its word and blocks input while full.
// ----------------------------------------------------------------------------
module simd_program_sequencer #(
    parameter int ADDR_BITS = sps_pkg::WORD_ADDR_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port
    input  logic                                 i_cfg_we,
    input  logic [sps_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [sps_pkg::CFG_WIDTH-1:0]        i_cfg_data,
    // Input items
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_restart,
    // Program words
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [sps_pkg::OP_BITS-1:0]          o_opcode,
    output logic [ADDR_BITS-1:0]                 o_address,
    output logic                                 o_last
);

    sps_pkg::t_cfg                      r_cfg;
    sps_pkg::t_state                    r_state;
    sps_pkg::t_state                    n_state;
    logic                               r_out_valid;
    logic [sps_pkg::OP_BITS-1:0]        r_opcode;
    logic [ADDR_BITS-1:0]               r_address;
    logic                               r_last;
    logic                               step_emit;
    logic [sps_pkg::OP_BITS-1:0]        step_opcode;
    logic [ADDR_BITS-1:0]               step_address;
    logic                               step_last;
    logic                               in_accept;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= 1'b0;
            r_cfg.elem_opcode <= sps_pkg::OP_ADD;
            r_cfg.rows        <= 9'd8;
            r_cfg.inner       <= 9'd8;
            r_cfg.cols        <= 9'd8;
            r_cfg.lanes_log2  <= 3'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sps_pkg::CFG_MODE:        r_cfg.mode        <= i_cfg_data[0];
                sps_pkg::CFG_ELEM_OPCODE: r_cfg.elem_opcode <= i_cfg_data[3:0];
                sps_pkg::CFG_ROWS:        r_cfg.rows        <= i_cfg_data;
                sps_pkg::CFG_INNER:       r_cfg.inner       <= i_cfg_data;
                sps_pkg::CFG_COLS:        r_cfg.cols        <= i_cfg_data;
                sps_pkg::CFG_LANES_LOG2:  r_cfg.lanes_log2  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Next-word logic.
    sps_step #(
        .ADDR_BITS (ADDR_BITS)
    ) u_step (
        .i_cfg     (r_cfg),
        .i_state   (r_state),
        .i_restart (i_restart),
        .o_state   (n_state),
        .o_emit    (step_emit),
        .o_opcode  (step_opcode),
        .o_address (step_address),
        .o_last    (step_last)
    );

    // Input is taken whenever the output register is empty or being drained.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // Loop position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= step_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && step_emit) begin
            r_opcode  <= step_opcode;
            r_address <= step_address;
            r_last    <= step_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_opcode    = r_opcode;
    assign o_address   = r_address;
    assign o_last      = r_last;

    // The closing flag only ever marks a STOP word.
    a_last_is_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_opcode == sps_pkg::OP_STOP))
        else $error("last flag on a word that is not STOP");

    // A restart always yields a NOP and starts the program.
    a_restart_nop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_restart) |=>
        (o_out_valid && o_opcode == sps_pkg::OP_NOP && !o_last && r_state.running))
        else $error("restart did not produce NOP");

    // An advance while idle produces no word.
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_restart && !r_state.running) |=> !o_out_valid)
        else $error("word produced while idle");

    // The program only stops by emitting the closing STOP.
    a_stop_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_state.running)) |-> (o_out_valid && o_last))
        else $error("program stopped without closing STOP");

endmodule

// ===== bench/simd_program_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// simd_program_sequencer_test
// Self-checking bench for the vector program sequencer. A cycle-level
// predictor follows the loop position and configuration of the block and
// works out the program word that each accepted item should produce. Words
// are compared field by field as they are transferred. Directed programs
// cover idle advances, restarts, bare lane groups, address wrap, empty
// programs and mid-program register changes. Random programs then run under
// four sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module simd_program_sequencer_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Elementwise operation code outside the named set.
    localparam logic [sps_pkg::OP_BITS-1:0] OP_UNDEF_F = 4'd15;

    // Register indexes that the block does not decode.
    localparam logic [sps_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [sps_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_B = 3'd7;

    // Cycles to let pass after the last word before touching registers.
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [sps_pkg::OP_BITS-1:0]        opcode;
        logic [sps_pkg::WORD_ADDR_BITS-1:0] address;
        logic                               last;
    } t_program_word;

    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_cfg_we    = 1'b0;
    logic [sps_pkg::CFG_IDX_BITS-1:0]     i_cfg_index = '0;
    logic [sps_pkg::CFG_WIDTH-1:0]        i_cfg_data  = '0;
    logic                                 i_in_valid  = 1'b0;
    logic                                 o_in_ready;
    logic                                 i_restart   = 1'b0;
    logic                                 o_out_valid;
    logic                                 i_out_ready = 1'b0;
    logic [sps_pkg::OP_BITS-1:0]          o_opcode;
    logic [sps_pkg::WORD_ADDR_BITS-1:0]   o_address;
    logic                                 o_last;

    // Predictor copy of the configuration and the loop position.
    sps_pkg::t_cfg             cfg_model;
    sps_pkg::t_state           seq_pos;
    t_program_word             expected_words[$];

    int unsigned               send_idle_pct = 0;
    int unsigned               stall_pct     = 0;
    int unsigned               hold_cycles   = 0;
    int unsigned               items_taken     = 0;
    int unsigned               words_predicted = 0;
    int unsigned               words_checked   = 0;
    int unsigned               restarts_seen   = 0;
    int unsigned               idle_advances   = 0;
    int unsigned               reg_writes      = 0;
    int unsigned               mismatches      = 0;

    int unsigned               send_idle_plan[4] = '{0, 72, 0, 31};
    int unsigned               stall_plan[4]     = '{0, 0, 72, 31};

    simd_program_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_opcode    (o_opcode),
        .o_address   (o_address),
        .o_last      (o_last)
    );

    // Free-running clock, 12 ns period.
    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Sizes above 256 behave as 256.
    function automatic int unsigned size_limit(logic [sps_pkg::SIZE_BITS-1:0] value);
        return (value > 9'd256) ? 32'd256 : 32'(value);
    endfunction

    function automatic t_program_word make_word(logic [sps_pkg::OP_BITS-1:0] op,
                                                int unsigned addr, logic last);
        t_program_word word;
        word.opcode  = op;
        word.address = addr[sps_pkg::WORD_ADDR_BITS-1:0];
        word.last    = last;
        return word;
    endfunction

    // The closing STOP word drops the sequencer back to idle.
    function automatic t_program_word close_program();
        seq_pos.running = 1'b0;
        seq_pos.phase   = sps_pkg::PH_IDLE;
        return make_word(sps_pkg::OP_STOP, 0, 1'b1);
    endfunction

    // Step to the next row, or to the final STOP after the last row.
    function automatic void advance_row(int unsigned m_lim);
        if (32'(seq_pos.row_index) + 1 >= m_lim) begin
            seq_pos.phase = sps_pkg::PH_FIN;
        end else begin
            seq_pos.row_index = 8'(32'(seq_pos.row_index) + 1);
            seq_pos.phase     = sps_pkg::PH_TOP;
        end
    endfunction

    function automatic void store_register(logic [sps_pkg::CFG_IDX_BITS-1:0] idx,
                                           logic [sps_pkg::CFG_WIDTH-1:0] data);
        case (idx)
            sps_pkg::CFG_MODE:        cfg_model.mode        = data[0];
            sps_pkg::CFG_ELEM_OPCODE: cfg_model.elem_opcode = data[sps_pkg::OP_BITS-1:0];
            sps_pkg::CFG_ROWS:        cfg_model.rows        = data;
            sps_pkg::CFG_INNER:       cfg_model.inner       = data;
            sps_pkg::CFG_COLS:        cfg_model.cols        = data;
            sps_pkg::CFG_LANES_LOG2:  cfg_model.lanes_log2  = data[2:0];
            default: ;
        endcase
    endfunction

    // Works out the word for one accepted item; returns 0 when none is due.
    function automatic bit next_program_word(input logic restart,
                                             output t_program_word word);
        int unsigned lg, lanes, m_lim, n_lim, p_lim, m, p, w, n, groups, addr;
        logic [2:0]  step;
        lg     = (cfg_model.lanes_log2 > 3'd4) ? 32'd4 : 32'(cfg_model.lanes_log2);
        lanes  = 32'd1 << lg;
        m_lim  = size_limit(cfg_model.rows);
        n_lim  = size_limit(cfg_model.inner);
        p_lim  = size_limit(cfg_model.cols);
        m      = 32'(seq_pos.row_index);
        p      = 32'(seq_pos.col_group_index);
        w      = 32'(seq_pos.lane_index);
        n      = 32'(seq_pos.inner_index);
        word   = make_word(sps_pkg::OP_NOP, 0, 1'b0);

        if (restart) begin
            seq_pos         = '0;
            seq_pos.phase   = sps_pkg::PH_TOP;
            seq_pos.running = 1'b1;
            return 1'b1;
        end
        if (!seq_pos.running) begin
            return 1'b0;
        end
        if (seq_pos.phase == sps_pkg::PH_FIN) begin
            word = close_program();
            return 1'b1;
        end

        // Matrix multiply program.
        if (!cfg_model.mode) begin
            groups = n_lim >> lg;
            step   = seq_pos.phase;
            if (step < sps_pkg::PH_LB || step > sps_pkg::PH_ST) begin
                if (m >= m_lim || p_lim == 0) begin
                    word = close_program();
                    return 1'b1;
                end
                if (n >= groups) begin
                    // No full inner group left: the lane closes with BUF2.
                    seq_pos.inner_index = '0;
                    step = sps_pkg::PH_BUF;
                end else begin
                    word = make_word(sps_pkg::OP_LOAD_A, ((m * n_lim) >> lg) + n, 1'b0);
                    seq_pos.phase = sps_pkg::PH_LB;
                    return 1'b1;
                end
            end
            case (step)
                sps_pkg::PH_LB: begin
                    word = make_word(sps_pkg::OP_LOAD_B,
                                     (((p + w) * n_lim) >> lg) + n, 1'b0);
                    seq_pos.phase = sps_pkg::PH_MID;
                end
                sps_pkg::PH_MID: begin
                    word = make_word(sps_pkg::OP_DOT, 0, 1'b0);
                    if (n + 1 >= groups) begin
                        seq_pos.inner_index = '0;
                        seq_pos.phase       = sps_pkg::PH_BUF;
                    end else begin
                        seq_pos.inner_index = 8'(n + 1);
                        seq_pos.phase       = sps_pkg::PH_TOP;
                    end
                end
                sps_pkg::PH_BUF: begin
                    word = make_word(sps_pkg::OP_BUF2, 0, 1'b0);
                    if (w + 1 >= lanes) begin
                        seq_pos.lane_index = '0;
                        seq_pos.phase      = sps_pkg::PH_ST;
                    end else begin
                        seq_pos.lane_index = sps_pkg::LANE_BITS'(w + 1);
                        seq_pos.phase      = sps_pkg::PH_TOP;
                    end
                end
                default: begin
                    word = make_word(sps_pkg::OP_STORE,
                                     ((m * p_lim) >> lg) + (p >> lg), 1'b0);
                    seq_pos.lane_index = '0;
                    if (p + lanes >= p_lim) begin
                        seq_pos.col_group_index = '0;
                        advance_row(m_lim);
                    end else begin
                        seq_pos.col_group_index = 8'(p + lanes);
                        seq_pos.phase           = sps_pkg::PH_TOP;
                    end
                end
            endcase
            return 1'b1;
        end

        // Elementwise program: five words per row and lane group.
        addr = ((m * n_lim) >> lg) + (n >> lg);
        case (seq_pos.phase)
            sps_pkg::PH_LB: begin
                word = make_word(sps_pkg::OP_LOAD_B, addr, 1'b0);
                seq_pos.phase = sps_pkg::PH_MID;
            end
            sps_pkg::PH_MID: begin
                word = make_word(cfg_model.elem_opcode, 0, 1'b0);
                seq_pos.phase = sps_pkg::PH_BUF;
            end
            sps_pkg::PH_BUF: begin
                word = make_word(sps_pkg::OP_BUF1, 0, 1'b0);
                seq_pos.phase = sps_pkg::PH_ST;
            end
            sps_pkg::PH_ST: begin
                word = make_word(sps_pkg::OP_STORE, addr, 1'b0);
                if (n + lanes >= n_lim) begin
                    seq_pos.inner_index = '0;
                    advance_row(m_lim);
                end else begin
                    seq_pos.inner_index = 8'(n + lanes);
                    seq_pos.phase       = sps_pkg::PH_TOP;
                end
            end
            default: begin
                if (m >= m_lim || n_lim == 0) begin
                    word = close_program();
                end else begin
                    word = make_word(sps_pkg::OP_LOAD_A, addr, 1'b0);
                    seq_pos.phase = sps_pkg::PH_LB;
                end
            end
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input t_program_word want,
                                   input t_program_word got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("ERROR at %0t ns: %s: expected op=%0d addr=%0d last=%0b,",
                     $time, what, want.opcode, want.address, want.last);
            $display("    got op=%0d addr=%0d last=%0b",
                     got.opcode, got.address, got.last);
        end
    endtask

    // Output words are checked before the item taken at the same edge is
    // predicted; a word never leaves in the cycle its item is taken.
    always @(posedge i_clk) begin : word_check
        t_program_word got;
        t_program_word want;
        t_program_word pred;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_opcode, o_address, o_last};
                words_checked++;
                if (expected_words.size() == 0) begin
                    report_mismatch("program word with none pending", '0, got);
                end else begin
                    want = expected_words.pop_front();
                    if (got.opcode !== want.opcode || got.address !== want.address ||
                        got.last !== want.last) begin
                        report_mismatch("program word mismatch", want, got);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                items_taken++;
                if (i_restart) begin
                    restarts_seen++;
                end
                if (next_program_word(i_restart, pred)) begin
                    expected_words.push_back(pred);
                    words_predicted++;
                end else begin
                    idle_advances++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles--;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Offers one item and returns at the falling edge after its transfer.
    task automatic send_item(input logic restart);
        int unsigned target;
        target = items_taken + 1;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        do @(negedge i_clk); while (items_taken != target);
    endtask

    // Holds the sender until every pending word has been transferred.
    task automatic drain_words();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_register(input logic [sps_pkg::CFG_IDX_BITS-1:0] idx,
                                  input logic [sps_pkg::CFG_WIDTH-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        store_register(idx, data);
        reg_writes++;
        @(negedge i_clk);
    endtask

    // Narrow registers sometimes get junk in the unused upper data bits.
    function automatic logic [sps_pkg::CFG_WIDTH-1:0] with_upper_noise(int unsigned value,
                                                                       int unsigned bits);
        logic [sps_pkg::CFG_WIDTH-1:0] noise;
        noise = ($urandom_range(0, 3) == 0) ? sps_pkg::CFG_WIDTH'($urandom_range(0, 511))
                                            : '0;
        return (noise << bits) | sps_pkg::CFG_WIDTH'(value);
    endfunction

    task automatic program_config(input int unsigned mode, input int unsigned op,
                                  input int unsigned rows, input int unsigned inner,
                                  input int unsigned cols, input int unsigned lanes_code);
        drain_words();
        write_register(sps_pkg::CFG_MODE, with_upper_noise(mode, 1));
        write_register(sps_pkg::CFG_ELEM_OPCODE, with_upper_noise(op, sps_pkg::OP_BITS));
        write_register(sps_pkg::CFG_ROWS, sps_pkg::CFG_WIDTH'(rows));
        write_register(sps_pkg::CFG_INNER, sps_pkg::CFG_WIDTH'(inner));
        write_register(sps_pkg::CFG_COLS, sps_pkg::CFG_WIDTH'(cols));
        write_register(sps_pkg::CFG_LANES_LOG2, with_upper_noise(lanes_code, 3));
        if ($urandom_range(0, 9) == 0) begin
            write_register($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B,
                           sps_pkg::CFG_WIDTH'($urandom_range(0, 511)));
        end
        i_cfg_we <= 1'b0;
    endtask

    // Mostly a few lane groups; now and then empty, full or oversized.
    function automatic int unsigned pick_size(int unsigned lanes);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return lanes * $urandom_range(1, 2);
        if (roll < 75) return $urandom_range(1, 2 * lanes + 1);
        if (roll < 82) return 0;
        if (roll < 90) return 256;
        if (roll < 95) return $urandom_range(257, 511);
        return $urandom_range(1, 255);
    endfunction

    task automatic random_config();
        int unsigned lanes_code, lanes, rows;
        lanes_code = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                  : $urandom_range(3, 7);
        lanes = 32'd1 << ((lanes_code > 4) ? 4 : lanes_code);
        rows  = ($urandom_range(0, 99) < 60) ? $urandom_range(1, 2) : pick_size(lanes);
        program_config($urandom_range(0, 1), $urandom_range(0, 15), rows,
                       pick_size(lanes), pick_size(lanes), lanes_code);
    endtask

    // One program from restart, with occasional restarts and register changes
    // along the way, and up to two more advances at the end, ignored once it has stopped.
    task automatic run_program(input int unsigned max_steps);
        int unsigned steps, roll;
        send_item(1'b1);
        steps = 0;
        while (seq_pos.running && steps < max_steps) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                send_item(1'b1);
            end else if (roll < 5) begin
                drain_words();
                write_register(sps_pkg::CFG_IDX_BITS'($urandom_range(0, 5)),
                               $urandom_range(0, 1)
                                   ? sps_pkg::CFG_WIDTH'($urandom_range(0, 511))
                                   : sps_pkg::CFG_WIDTH'($urandom_range(0, 8)));
                i_cfg_we <= 1'b0;
                send_item(1'b0);
            end else begin
                send_item(1'b0);
            end
            steps++;
        end
        repeat ($urandom_range(0, 2)) send_item(1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Advance while idle, then restarts at and inside the reset-default program.
    task automatic test_idle_and_restart();
        send_item(1'b0);
        send_item(1'b1);
        repeat (3) send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
    endtask

    // Switch to elementwise with an oversized lane count in the middle of a
    // matrix program; the loop position carries over.
    task automatic test_config_mid_program();
        drain_words();
        write_register(sps_pkg::CFG_MODE, 9'd1);
        write_register(sps_pkg::CFG_LANES_LOG2, 9'd7);
        i_cfg_we <= 1'b0;
        repeat (2) send_item(1'b0);
    endtask

    // Inner size below the lane count: every lane is a bare BUF2.
    task automatic test_bare_lane_groups();
        program_config(0, sps_pkg::OP_ADD, 1, 1, 1, 1);
        send_item(1'b1);
        repeat (5) send_item(1'b0);
    endtask

    // One elementwise row under a single-column shape, then a wide inner
    // size pushes the row base past the address range.
    task automatic test_address_wrap();
        program_config(1, OP_UNDEF_F, 9'h1FF, 1, 1, 0);
        send_item(1'b1);
        repeat (5) send_item(1'b0);
        drain_words();
        write_register(sps_pkg::CFG_INNER, 9'd256);
        i_cfg_we <= 1'b0;
        repeat (2) send_item(1'b0);
    endtask

    // Zero columns in matrix mode gives NOP and STOP only.
    task automatic test_empty_program();
        drain_words();
        write_register(CFG_UNUSED_B, 9'h1FF);
        i_cfg_we <= 1'b0;
        program_config(0, sps_pkg::OP_ADD, 8, 8, 0, 2);
        send_item(1'b1);
        repeat (2) send_item(1'b0);
    endtask

    task automatic test_random_programs();
        int unsigned goal;
        for (int mix = 0; mix < 4; mix++) begin
            send_idle_pct = send_idle_plan[mix];
            stall_pct     = stall_plan[mix];
            goal          = words_predicted + 135;
            if (mix == 0) begin
                // Long receiver hold-off while a long program keeps coming.
                program_config(0, sps_pkg::OP_ADD, 8, 8, 8, 2);
                hold_cycles = 60;
                run_program(100);
            end
            while (words_predicted < goal) begin
                random_config();
                run_program($urandom_range(30, 90));
            end
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    // ------------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------------

    initial begin
        cfg_model = '{mode: 1'b0, elem_opcode: sps_pkg::OP_ADD, rows: 9'd8, inner: 9'd8,
                      cols: 9'd8, lanes_log2: 3'd2};
        seq_pos   = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_idle_and_restart();
        test_config_mid_program();
        test_bare_lane_groups();
        test_address_wrap();
        test_empty_program();
        test_random_programs();

        drain_words();
        if (expected_words.size() != 0) begin
            mismatches++;
        end
        $display("Checked %0d program words from %0d restarts; %0d advances were ignored.",
                 words_checked, restarts_seen, idle_advances);
        $display("Both program modes ran over %0d register writes and four idling mixes.",
                 reg_writes);
        if (mismatches == 0) begin
            $display("simd_program_sequencer_test passed");
        end else begin
            $display("simd_program_sequencer_test failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #5ms;
        $display("Timeout with %0d program words still pending.", expected_words.size());
        $display("simd_program_sequencer_test failed");
        $finish;
    end

endmodule
